@@ src/phtc_pkg.sv @@
package phtc_pkg;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam int OUT_CW = 48;

	typedef enum logic [0:0] {
		FUNC_PKT  = 1'b0,
		FUNC_DUMP = 1'b1
	} func_t;

	typedef enum logic [0:0] {
		KIND_HOST    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic [0:0] {
		REG_LOCAL_NET  = 1'b0,
		REG_LOCAL_MASK = 1'b1
	} reg_idx_t;

	// Classified command handed from the front part to the back part.
	typedef struct packed {
		logic        dump;
		logic        src_hit;
		logic        dst_hit;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] frame_len;
	} cmd_t;

endpackage

@@ src/phtc_if.sv @@
interface phtc_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] eth_type;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] frame_len;

	modport source (output valid, func, eth_type, src_ip, dst_ip, frame_len, input ready);
	modport sink (input valid, func, eth_type, src_ip, dst_ip, frame_len, output ready);
endinterface

interface phtc_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] address;
	logic [47:0] pass_rx;
	logic [47:0] pass_tx;
	logic [47:0] total_rx;
	logic [47:0] total_tx;
	logic [31:0] table_overflows;
	logic        is_last;

	modport source (output valid, kind, address, pass_rx, pass_tx, total_rx, total_tx,
		table_overflows, is_last, input ready);
	modport sink (input valid, kind, address, pass_rx, pass_tx, total_rx, total_tx,
		table_overflows, is_last, output ready);
endinterface

@@ src/phtc_front.sv @@
module phtc_front import phtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	phtc_in_if.sink     in_ch,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	logic [31:0] net_q;
	logic [31:0] mask_q;
	logic        src_hit;
	logic        dst_hit;
	logic        is_dump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q  <= '0;
			mask_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_LOCAL_NET:  net_q  <= cfg_data;
				REG_LOCAL_MASK: mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_dump = (in_ch.func == FUNC_DUMP);
		src_hit = (in_ch.eth_type == ETH_IPV4) && ((in_ch.src_ip & mask_q) == net_q);
		dst_hit = (in_ch.eth_type == ETH_IPV4) && ((in_ch.dst_ip & mask_q) == net_q);
		cmd.dump      = is_dump;
		cmd.src_hit   = src_hit && !is_dump;
		cmd.dst_hit   = dst_hit && !is_dump;
		cmd.src_ip    = in_ch.src_ip;
		cmd.dst_ip    = in_ch.dst_ip;
		cmd.frame_len = in_ch.frame_len;
	end

	// Drop items that touch nothing; pass the rest to the queue.
	assign cmd_valid   = in_ch.valid && (cmd.dump || cmd.src_hit || cmd.dst_hit);
	assign in_ch.ready = cmd_ready || !(cmd.dump || cmd.src_hit || cmd.dst_hit);

endmodule

@@ src/phtc_fifo.sv @@
module phtc_fifo import phtc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count beyond depth");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");
`endif

endmodule

@@ src/phtc_back.sv @@
module phtc_back import phtc_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	parameter int COUNT_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	phtc_out_if.source out_ch
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOOK   = 6'b000010,
		ST_RD     = 6'b000100,
		ST_WR     = 6'b001000,
		ST_DUMP   = 6'b010000,
		ST_SUM    = 6'b100000
	} state_t;

	state_t                 st_q;
	cmd_t                   cmd_q;
	logic                   side_q;      // 0 source (tx), 1 destination (rx)
	logic [CW-1:0]          fill_q;
	logic [IW-1:0]          idx_q;
	logic                   new_q;
	logic                   skip_q;
	logic [31:0]            addr_q [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] prx_mem [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] ptx_mem [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] trx_mem [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] ttx_mem [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] prx_q, ptx_q, trx_q, ttx_q;
	logic [COUNT_WIDTH-1:0] run_rx_q, run_tx_q, grand_rx_q, grand_tx_q;
	logic [31:0]            ovf_q;
	logic [31:0]            key;
	logic                   hit;
	logic [IW-1:0]          hit_idx;
	logic                   out_busy;
	logic                   emit;
	logic [COUNT_WIDTH-1:0] len_w;
	logic [COUNT_WIDTH-1:0] a_pass, a_tot;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? CMAX : s[COUNT_WIDTH-1:0];
	endfunction

	assign key   = side_q ? cmd_q.dst_ip : cmd_q.src_ip;
	assign len_w = COUNT_WIDTH'(cmd_q.frame_len);

	// Address match against the filled entries; entries are registers.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if ((CW'(i) < fill_q) && (addr_q[i] == key) && !hit) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	assign out_busy  = out_ch.valid && !out_ch.ready;
	assign emit      = (st_q == ST_DUMP || st_q == ST_SUM) && !out_busy;
	assign cmd_ready = (st_q == ST_IDLE);
	assign a_pass    = side_q ? sat_add(prx_q, len_w) : sat_add(ptx_q, len_w);
	assign a_tot     = side_q ? sat_add(trx_q, len_w) : sat_add(ttx_q, len_w);

	// Counter memories: one read and one write per cycle.
	always_ff @(posedge clk) begin
		if (st_q == ST_RD || st_q == ST_DUMP) begin
			prx_q <= prx_mem[idx_q];
			ptx_q <= ptx_mem[idx_q];
			trx_q <= trx_mem[idx_q];
			ttx_q <= ttx_mem[idx_q];
		end
		if (st_q == ST_WR && !skip_q) begin
			if (side_q) begin
				prx_mem[idx_q] <= new_q ? len_w : a_pass;
				trx_mem[idx_q] <= new_q ? len_w : a_tot;
				if (new_q) begin
					ptx_mem[idx_q] <= '0;
					ttx_mem[idx_q] <= '0;
				end
			end else begin
				ptx_mem[idx_q] <= new_q ? len_w : a_pass;
				ttx_mem[idx_q] <= new_q ? len_w : a_tot;
				if (new_q) begin
					prx_mem[idx_q] <= '0;
					trx_mem[idx_q] <= '0;
				end
			end
		end
		if (st_q == ST_DUMP && !out_busy) begin
			prx_mem[idx_q] <= '0;
			ptx_mem[idx_q] <= '0;
		end
		if (st_q == ST_LOOK && !hit && (fill_q < CW'(TABLE_DEPTH))) begin
			addr_q[fill_q[IW-1:0]] <= key;
		end
		if (st_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			side_q       <= 1'b0;
			fill_q       <= '0;
			idx_q        <= '0;
			new_q        <= 1'b0;
			skip_q       <= 1'b0;
			run_rx_q     <= '0;
			run_tx_q     <= '0;
			grand_rx_q   <= '0;
			grand_tx_q   <= '0;
			ovf_q        <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && !emit) out_ch.valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.dump) begin
							grand_rx_q <= sat_add(grand_rx_q, run_rx_q);
							grand_tx_q <= sat_add(grand_tx_q, run_tx_q);
							idx_q      <= '0;
							st_q       <= (fill_q == '0) ? ST_SUM : ST_DUMP;
						end else begin
							side_q <= !cmd.src_hit;
							st_q   <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					skip_q <= 1'b0;
					new_q  <= 1'b0;
					if (hit) begin
						idx_q <= hit_idx;
					end else if (fill_q < CW'(TABLE_DEPTH)) begin
						idx_q  <= fill_q[IW-1:0];
						new_q  <= 1'b1;
						fill_q <= fill_q + CW'(1);
					end else begin
						skip_q <= 1'b1;
						if (ovf_q != '1) ovf_q <= ovf_q + 32'd1;
					end
					if (side_q) run_rx_q <= sat_add(run_rx_q, len_w);
					else run_tx_q <= sat_add(run_tx_q, len_w);
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_WR;
				ST_WR: begin
					if (!side_q && cmd_q.dst_hit) begin
						side_q <= 1'b1;
						st_q   <= ST_LOOK;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					// One entry a cycle while the output is not busy: read, emit, clear pass counts.
					if (!out_busy) begin
						out_ch.valid           <= 1'b1;
						out_ch.kind            <= KIND_HOST;
						out_ch.address         <= addr_q[idx_q];
						out_ch.pass_rx         <= OUT_CW'(prx_mem[idx_q]);
						out_ch.pass_tx         <= OUT_CW'(ptx_mem[idx_q]);
						out_ch.total_rx        <= OUT_CW'(trx_mem[idx_q]);
						out_ch.total_tx        <= OUT_CW'(ttx_mem[idx_q]);
						out_ch.table_overflows <= '0;
						out_ch.is_last         <= 1'b0;
						if (CW'(idx_q) + CW'(1) == fill_q) st_q <= ST_SUM;
						else idx_q <= idx_q + IW'(1);
					end
				end
				ST_SUM: begin
					if (!out_busy) begin
						out_ch.valid           <= 1'b1;
						out_ch.kind            <= KIND_SUMMARY;
						out_ch.address         <= '0;
						out_ch.pass_rx         <= OUT_CW'(run_rx_q);
						out_ch.pass_tx         <= OUT_CW'(run_tx_q);
						out_ch.total_rx        <= OUT_CW'(grand_rx_q);
						out_ch.total_tx        <= OUT_CW'(grand_tx_q);
						out_ch.table_overflows <= ovf_q;
						out_ch.is_last         <= 1'b1;
						run_rx_q               <= '0;
						run_tx_q               <= '0;
						st_q                   <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH)) else $error("table fill beyond depth");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> $past(st_q) == ST_LOOK) else $error("fill moved outside lookup");
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SUM && !out_busy |=> out_ch.valid && out_ch.is_last) else $error("summary lost");
`endif

endmodule

@@ src/per_host_traffic_counter.sv @@
// Per-host byte counter for IPv4 traffic. Each packet beat is classified in the
// front part against local_net/local_mask and, if it touches a local host,
// queued to the back part, which looks the host up in a TABLE_DEPTH-entry table
// (inserted on first sight, never removed) and does a read-modify-write of its
// counters: it takes the command, then does lookup, read and write for each local
// side it touches; packets that match nothing are dropped by the front part. An
// end-of-pass beat emits one host beat per stored entry (one per cycle while the
// sink is ready), then a summary beat with is_last set, and clears the pass
// counts. Counters saturate at 2^COUNT_WIDTH-1; outputs carry the low 48 bits.
// Write config only while idle.
module per_host_traffic_counter import phtc_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	parameter int COUNT_WIDTH = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	phtc_in_if.sink     in_ch,
	phtc_out_if.source  out_ch
);

	cmd_t f_cmd;
	cmd_t b_cmd;
	logic f_valid, f_ready;
	logic b_valid, b_ready;

	// Classify and filter.
	phtc_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch), .cmd_valid(f_valid),
		.cmd_ready(f_ready), .cmd(f_cmd)
	);

	// Decouple front and back.
	phtc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_cmd), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	// Table update and dump.
	phtc_back #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.cmd(b_cmd), .out_ch(out_ch)
	);

endmodule

@@ dv/tb_per_host_traffic_counter.sv @@
`timescale 1ns / 100ps

module tb_per_host_traffic_counter;
	import phtc_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;
	// Packets that hit nothing leave no result, so give the back part time to retire them.
	localparam int SETTLE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		kind_t       kind;
		logic [31:0] address;
		logic [47:0] pass_rx;
		logic [47:0] pass_tx;
		logic [47:0] total_rx;
		logic [47:0] total_tx;
		logic [31:0] table_overflows;
		logic        is_last;
	} host_record_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_idx;
	logic [31:0] cfg_data;

	phtc_in_if  in_ch ();
	phtc_out_if out_ch ();

	per_host_traffic_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch.sink),
		.out_ch   (out_ch.source)
	);

	// Shadow copy of the counter state, advanced on every accepted input beat.
	logic [31:0] net_q, mask_q;
	logic        ent_valid [DEPTH];
	logic [31:0] ent_addr  [DEPTH];
	logic [47:0] ent_prx   [DEPTH];
	logic [47:0] ent_ptx   [DEPTH];
	logic [47:0] ent_trx   [DEPTH];
	logic [47:0] ent_ttx   [DEPTH];
	logic [47:0] run_rx_q, run_tx_q, grand_rx_q, grand_tx_q;
	logic [31:0] ovf_q;

	host_record_t expected_records [$];

	int errors = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_request = 0;
	int hold_cnt = 0;
	int stall_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Add with saturation at the 48-bit counter ceiling.
	function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
		logic [48:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[48] ? CNT_MAX : sum[47:0];
	endfunction

	// Find the host's slot, claiming the first free one on first sight; -1 when full.
	function automatic int host_slot(logic [31:0] addr);
		for (int i = 0; i < DEPTH; i++)
			if (ent_valid[i] && ent_addr[i] == addr)
				return i;
		for (int i = 0; i < DEPTH; i++) begin
			if (!ent_valid[i]) begin
				ent_valid[i] = 1'b1;
				ent_addr[i]  = addr;
				ent_prx[i]   = '0;
				ent_ptx[i]   = '0;
				ent_trx[i]   = '0;
				ent_ttx[i]   = '0;
				return i;
			end
		end
		if (ovf_q != 32'hFFFF_FFFF)
			ovf_q++;
		return -1;
	endfunction

	task automatic count_beat(func_t func, logic [15:0] etype, logic [31:0] src,
			logic [31:0] dst, logic [15:0] len);
		int slot;
		host_record_t rec;
		if (func == FUNC_PKT) begin
			if (etype != ETH_IPV4)
				return;
			if ((src & mask_q) == net_q) begin
				slot = host_slot(src);
				if (slot >= 0) begin
					ent_ttx[slot] = sat_add(ent_ttx[slot], 48'(len));
					ent_ptx[slot] = sat_add(ent_ptx[slot], 48'(len));
				end
				run_tx_q = sat_add(run_tx_q, 48'(len));
			end
			if ((dst & mask_q) == net_q) begin
				slot = host_slot(dst);
				if (slot >= 0) begin
					ent_trx[slot] = sat_add(ent_trx[slot], 48'(len));
					ent_prx[slot] = sat_add(ent_prx[slot], 48'(len));
				end
				run_rx_q = sat_add(run_rx_q, 48'(len));
			end
			return;
		end
		// End of pass: fold run totals first, then one beat per host, then the summary.
		grand_rx_q = sat_add(grand_rx_q, run_rx_q);
		grand_tx_q = sat_add(grand_tx_q, run_tx_q);
		for (int i = 0; i < DEPTH; i++) begin
			if (!ent_valid[i])
				continue;
			rec = '{KIND_HOST, ent_addr[i], ent_prx[i], ent_ptx[i], ent_trx[i], ent_ttx[i],
				32'd0, 1'b0};
			expected_records.push_back(rec);
			ent_prx[i] = '0;
			ent_ptx[i] = '0;
		end
		rec = '{KIND_SUMMARY, 32'd0, run_rx_q, run_tx_q, grand_rx_q, grand_tx_q, ovf_q, 1'b1};
		expected_records.push_back(rec);
		run_rx_q = '0;
		run_tx_q = '0;
	endtask

	// Offer one beat, hold it until accepted, and leave valid high for the caller.
	task automatic send_beat(func_t func, logic [15:0] etype, logic [31:0] src,
			logic [31:0] dst, logic [15:0] len);
		if ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.func      <= func;
		in_ch.eth_type  <= etype;
		in_ch.src_ip    <= src;
		in_ch.dst_ip    <= dst;
		in_ch.frame_len <= len;
		do
			@(posedge clk);
		while (!in_ch.ready);
		count_beat(func, etype, src, dst, len);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected beat has come out.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_records.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		if (idx == REG_LOCAL_NET)
			net_q = value;
		else
			mask_q = value;
	endtask

	task automatic set_network(logic [31:0] net, logic [31:0] mask);
		drain();
		write_reg(REG_LOCAL_NET, net);
		write_reg(REG_LOCAL_MASK, mask);
	endtask

	// Addresses drawn mostly from a small pool under 10.0.0.0 so hosts recur.
	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 32'h0A00_0000 | 32'($urandom_range(23));
		else if (r < 75)
			return 32'h0A00_0000 | 32'($urandom_range(24, 255));
		return $urandom;
	endfunction

	task automatic send_random(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 8)
				send_beat(FUNC_DUMP, 16'($urandom), $urandom, $urandom, 16'($urandom));
			else if (r < 18)
				send_beat(FUNC_PKT, 16'($urandom), $urandom, $urandom, 16'($urandom));
			else if (r < 26)
				send_beat(FUNC_PKT, 16'($urandom), $urandom, $urandom, 16'($urandom));
			else
				send_beat(FUNC_PKT, ETH_IPV4, pick_addr(), pick_addr(), 16'($urandom));
		end
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
	endtask

	task automatic test_directed();
		set_network(32'h0000_0000, 32'h0000_0000);
		// Every IPv4 address is local with a zero mask.
		send_beat(FUNC_PKT, 16'h86DD, 32'h0A00_0001, 32'h0A00_0002, 16'd100);
		send_beat(FUNC_PKT, 16'hFFFF, 32'h0A00_0001, 32'h0A00_0002, 16'd100);
		send_beat(FUNC_PKT, ETH_IPV4, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(FUNC_PKT, ETH_IPV4, 32'hFFFF_FFFF, 32'h0000_0000, 16'd0);
		send_beat(FUNC_PKT, ETH_IPV4, 32'h0A00_0001, 32'h0A00_0001, 16'd64);
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
		send_beat(FUNC_DUMP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		set_network(32'h0A00_0000, 32'hFFFF_FF00);
		send_beat(FUNC_PKT, ETH_IPV4, 32'h0A00_0003, 32'hC0A8_0001, 16'd1500);
		send_beat(FUNC_PKT, ETH_IPV4, 32'hC0A8_0001, 32'h0A00_0004, 16'd40);
		send_beat(FUNC_PKT, ETH_IPV4, 32'hC0A8_0001, 32'hC0A8_0002, 16'd40);
		send_beat(FUNC_PKT, ETH_IPV4, 32'h0A00_0003, 32'h0A00_0004, 16'd9000);
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
		set_network(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(FUNC_PKT, ETH_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 16'd77);
		send_beat(FUNC_PKT, ETH_IPV4, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'd1);
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
		// Nonzero net under a zero mask matches nothing.
		set_network(32'h0A00_0000, 32'h0000_0000);
		send_beat(FUNC_PKT, ETH_IPV4, 32'h0A00_0000, 32'h0A00_0000, 16'd5);
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
	endtask

	task automatic test_backpressure();
		set_network(32'h0A00_0000, 32'hFFFF_FF00);
		src_idle_pct = 26;
		snk_idle_pct = 48;
		send_random(40);
		// Stall the sink long enough that the dump backs up into the input.
		hold_request = 400;
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
		for (int n = 0; n < 12; n++)
			send_beat(FUNC_PKT, ETH_IPV4, pick_addr(), pick_addr(), 16'($urandom));
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
		send_random(30);
	endtask

	task automatic test_sender_gaps();
		set_network(32'h0A00_0000, 32'hFFFF_0000);
		src_idle_pct = 48;
		snk_idle_pct = 26;
		send_random(85);
	endtask

	task automatic test_table_full();
		set_network(32'h0000_0000, 32'h0000_0000);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		// Fresh hosts on both sides until well past the table depth.
		for (int n = 0; n < 24; n++)
			send_beat(FUNC_PKT, ETH_IPV4, 32'hAC10_0000 | 32'(2 * n),
				32'hAC10_0001 | 32'(2 * n), 16'($urandom));
		send_beat(FUNC_DUMP, '0, '0, '0, '0);
		send_random(70);
	endtask

	// Sink side: random ready, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_cnt = hold_request;
			hold_request = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Compare each accepted output beat with the oldest expectation.
	always @(posedge clk) begin
		host_record_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_records.size() == 0) begin
				$error("unexpected output beat, address %h", out_ch.address);
				errors++;
			end else begin
				want = expected_records.pop_front();
				if (out_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
					errors++;
				end
				if (out_ch.address !== want.address) begin
					$error("address: expected %h, got %h", want.address, out_ch.address);
					errors++;
				end
				if (out_ch.pass_rx !== want.pass_rx) begin
					$error("pass_rx: expected %0d, got %0d", want.pass_rx, out_ch.pass_rx);
					errors++;
				end
				if (out_ch.pass_tx !== want.pass_tx) begin
					$error("pass_tx: expected %0d, got %0d", want.pass_tx, out_ch.pass_tx);
					errors++;
				end
				if (out_ch.total_rx !== want.total_rx) begin
					$error("total_rx: expected %0d, got %0d", want.total_rx, out_ch.total_rx);
					errors++;
				end
				if (out_ch.total_tx !== want.total_tx) begin
					$error("total_tx: expected %0d, got %0d", want.total_tx, out_ch.total_tx);
					errors++;
				end
				if (out_ch.table_overflows !== want.table_overflows) begin
					$error("table_overflows: expected %0d, got %0d", want.table_overflows,
						out_ch.table_overflows);
					errors++;
				end
				if (out_ch.is_last !== want.is_last) begin
					$error("is_last: expected %0d, got %0d", want.is_last, out_ch.is_last);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = REG_LOCAL_NET;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.func      = FUNC_PKT;
		in_ch.eth_type  = '0;
		in_ch.src_ip    = '0;
		in_ch.dst_ip    = '0;
		in_ch.frame_len = '0;
		out_ch.ready    = 1'b0;
		net_q = '0;
		mask_q = '0;
		run_rx_q = '0;
		run_tx_q = '0;
		grand_rx_q = '0;
		grand_tx_q = '0;
		ovf_q = '0;
		for (int i = 0; i < DEPTH; i++)
			ent_valid[i] = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_sender_gaps();
		test_table_full();
		drain();

		if (errors == 0 && expected_records.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
